### sv/ec2d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ec2d_pkg;

    // Fraction bits of the unit normal (Q1.28) and of the mass weight (Q0.30).
    localparam int NORM_BITS   = 28;
    localparam int WEIGHT_BITS = 30;

    // Working width of the rounding helper; every caller sign-extends into it.
    localparam int RND_W = 68;

    typedef struct packed {
        logic signed [31:0] first_pos_x;
        logic signed [31:0] first_pos_y;
        logic signed [31:0] second_pos_x;
        logic signed [31:0] second_pos_y;
        logic signed [31:0] first_vel_x;
        logic signed [31:0] first_vel_y;
        logic signed [31:0] second_vel_x;
        logic signed [31:0] second_vel_y;
        logic        [31:0] first_mass;
        logic        [31:0] second_mass;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] first_new_vel_x;
        logic signed [31:0] first_new_vel_y;
        logic signed [31:0] second_new_vel_x;
        logic signed [31:0] second_new_vel_y;
        logic               degenerate;
        logic               saturated;
    } t_out_res;

    typedef struct packed {
        logic signed [31:0] avx;
        logic signed [31:0] avy;
        logic signed [31:0] bvx;
        logic signed [31:0] bvy;
    } t_vel;

    // Divide by 2^NORM_BITS, rounding to nearest with ties away from zero.
    function automatic logic signed [RND_W-1:0] rnd_norm(input logic signed [RND_W-1:0] x);
        logic [RND_W-1:0] mag;
        logic [RND_W-1:0] q;
        mag = x[RND_W-1] ? RND_W'(-x) : RND_W'(x);
        q   = (mag + (RND_W'(1) << (NORM_BITS - 1))) >> NORM_BITS;
        return x[RND_W-1] ? -$signed(q) : $signed(q);
    endfunction

    // Returns the clamped 32-bit value with the clamp flag on top.
    function automatic logic [32:0] clamp32(input logic signed [39:0] v);
        logic [32:0] res;
        if (v > 40'sd2147483647) begin
            res = {1'b1, 32'h7fff_ffff};
        end else if (v < -40'sd2147483648) begin
            res = {1'b1, 32'h8000_0000};
        end else begin
            res = {1'b0, v[31:0]};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### sv/ec2d_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module ec2d_isqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_rad,
    output logic [31:0] o_root
);

    localparam int STEPS = 32;

    logic [63:0] r_rem  [0:STEPS-1];
    logic [63:0] r_root [0:STEPS-1];

    // One result bit per stage, trial bit walking down from 2^62 by powers of four.
    for (genvar s = 0; s < STEPS; s++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * s);
        logic [63:0] rem_in;
        logic [63:0] root_in;
        logic [63:0] trial;

        if (s == 0) begin : g_first
            assign rem_in  = i_rad;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[s-1];
            assign root_in = r_root[s-1];
        end

        assign trial = root_in + BIT;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (rem_in >= trial) begin
                    r_rem[s]  <= rem_in - trial;
                    r_root[s] <= (root_in >> 1) + BIT;
                end else begin
                    r_rem[s]  <= rem_in;
                    r_root[s] <= root_in >> 1;
                end
            end
        end
    end

    assign o_root = r_root[STEPS-1][31:0];

endmodule

`default_nettype wire

### sv/ec2d_div.sv
`timescale 1ns / 1ps
`default_nettype none

module ec2d_div #(
    parameter int NUM_W = 60,
    parameter int DEN_W = 32,
    parameter int Q_W   = 31
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [Q_W-1:0]   o_quo
);

    localparam int RW = DEN_W + Q_W;

    logic [RW-1:0]    r_rem [0:Q_W-1];
    logic [DEN_W-1:0] r_den [0:Q_W-1];
    logic [Q_W-1:0]   r_quo [0:Q_W-1];

    // Restoring division, one quotient bit per stage from the top bit down.
    // The caller guarantees that the quotient fits in Q_W bits.
    for (genvar s = 0; s < Q_W; s++) begin : g_step
        localparam int B = Q_W - 1 - s;
        logic [RW-1:0]    rem_in;
        logic [DEN_W-1:0] den_in;
        logic [Q_W-1:0]   quo_in;
        logic [RW-1:0]    trial;
        logic             take;

        if (s == 0) begin : g_first
            assign rem_in = RW'(i_num);
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign den_in = r_den[s-1];
            assign quo_in = r_quo[s-1];
        end

        assign trial = RW'(den_in) << B;
        assign take  = (rem_in >= trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= take ? (rem_in - trial) : rem_in;
                r_den[s] <= den_in;
                r_quo[s] <= quo_in | (take ? (Q_W'(1) << B) : Q_W'(0));
            end
        end
    end

    assign o_quo = r_quo[Q_W-1];

endmodule

`default_nettype wire

### sv/ec2d_delay.sv
`timescale 1ns / 1ps
`default_nettype none

module ec2d_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_vld,
    input  logic [W-1:0] i_data,
    output logic         o_vld,
    output logic [W-1:0] o_data
);

    logic         r_vld  [0:DEPTH-1];
    logic [W-1:0] r_data [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int k = 1; k < DEPTH; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data[0] <= i_data;
            for (int k = 1; k < DEPTH; k++) begin
                r_data[k] <= r_data[k-1];
            end
        end
    end

    assign o_vld  = r_vld[DEPTH-1];
    assign o_data = r_data[DEPTH-1];

endmodule

`default_nettype wire

### sv/elastic_collision_2d.sv
`timescale 1ns / 1ps
`default_nettype none

// Two-body elastic collision in the plane, Q16.16 in and out. The block takes one
// request per clock cycle while o_stall is low and returns each result in order;
// most of the pipeline is the 32-stage square root that gives the center distance
// and the 31-stage dividers that form the unit normal and the mass weight, which
// run side by side. A stall on the result side while o_valid is high freezes the
// whole pipeline, and o_stall follows it in the same cycle. Coincident centers or a
// zero mass sum pass the velocities through with degenerate set; otherwise each
// velocity component is clamped to 32 bits and saturated reports any clamp.
module elastic_collision_2d (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  ec2d_pkg::t_in_req   i_req,
    output logic                o_valid,
    input  logic                i_stall,
    output ec2d_pkg::t_out_res  o_res
);

    typedef struct packed {
        logic               x_neg;
        logic               y_neg;
        logic               degen;
        logic [31:0]        mb;
        logic [32:0]        msum;
        ec2d_pkg::t_vel     vel;
    } t_front;

    typedef struct packed {
        logic [30:0]        mxn;
        logic [30:0]        myn;
        t_front             fr;
    } t_side_a;

    typedef struct packed {
        logic               x_neg;
        logic               y_neg;
        logic               degen;
        ec2d_pkg::t_vel     vel;
    } t_side_b;

    typedef struct packed {
        logic               degen;
        ec2d_pkg::t_vel     vel;
        logic signed [29:0] nx;
        logic signed [29:0] ny;
        logic [30:0]        wb;
    } t_back;

    logic pipe_en;

    // Valid bits of the explicit stages.
    logic r_s1_vld, r_s2_vld, r_s3_vld, r_s38_vld, r_n_vld;
    logic r_p1_vld, r_p2_vld, r_p3_vld, r_p4_vld, r_p5_vld;
    logic r_p6_vld, r_p7_vld, r_p8_vld, r_p9_vld, r_out_vld;

    assign pipe_en = !(r_out_vld && i_stall);
    assign o_stall = r_out_vld && i_stall;
    assign o_valid = r_out_vld;

    // ---------------- Stage 1: center difference and magnitudes ----------------
    logic signed [32:0] dx, dy;
    logic [32:0]        msum;
    logic [31:0]        r_s1_mx, r_s1_my;
    t_front             r_s1_fr;

    assign dx   = 33'(i_req.first_pos_x) - 33'(i_req.second_pos_x);
    assign dy   = 33'(i_req.first_pos_y) - 33'(i_req.second_pos_y);
    assign msum = 33'(i_req.first_mass) + 33'(i_req.second_mass);

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_s1_mx          <= 32'(dx[32] ? -dx : dx);
            r_s1_my          <= 32'(dy[32] ? -dy : dy);
            r_s1_fr.x_neg    <= dx[32];
            r_s1_fr.y_neg    <= dy[32];
            r_s1_fr.degen    <= ((dx == '0) && (dy == '0)) || (msum == '0);
            r_s1_fr.mb       <= i_req.second_mass;
            r_s1_fr.msum     <= msum;
            r_s1_fr.vel.avx  <= i_req.first_vel_x;
            r_s1_fr.vel.avy  <= i_req.first_vel_y;
            r_s1_fr.vel.bvx  <= i_req.second_vel_x;
            r_s1_fr.vel.bvy  <= i_req.second_vel_y;
        end
    end

    // ---------------- Stage 2: normalizing shift amount ----------------
    logic [31:0] mm;
    logic [4:0]  lsh;
    logic [31:0] r_s2_mx, r_s2_my;
    logic        r_s2_shr;
    logic [4:0]  r_s2_lsh;
    t_front      r_s2_fr;

    assign mm = (r_s1_mx > r_s1_my) ? r_s1_mx : r_s1_my;

    // Left shift that brings the larger magnitude up to bit 30.
    always_comb begin
        lsh = '0;
        for (int i = 0; i < 31; i++) begin
            if (mm[i]) begin
                lsh = 5'(30 - i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_s2_mx  <= r_s1_mx;
            r_s2_my  <= r_s1_my;
            r_s2_shr <= mm[31];
            r_s2_lsh <= lsh;
            r_s2_fr  <= r_s1_fr;
        end
    end

    // ---------------- Stage 3: apply the shift ----------------
    logic [30:0] r_s3_mxn, r_s3_myn;
    t_front      r_s3_fr;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_s3_mxn <= r_s2_shr ? 31'(r_s2_mx >> 1) : 31'(r_s2_mx << r_s2_lsh);
            r_s3_myn <= r_s2_shr ? 31'(r_s2_my >> 1) : 31'(r_s2_my << r_s2_lsh);
            r_s3_fr  <= r_s2_fr;
        end
    end

    // ---------------- Stages 4-5: squared length ----------------
    logic [61:0] r_s4_sqx, r_s4_sqy;
    logic [62:0] r_s5_sum;
    logic [31:0] len;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_s4_sqx <= 62'(r_s3_mxn) * 62'(r_s3_mxn);
            r_s4_sqy <= 62'(r_s3_myn) * 62'(r_s3_myn);
            r_s5_sum <= 63'(r_s4_sqx) + 63'(r_s4_sqy);
        end
    end

    ec2d_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (pipe_en),
        .i_rad  (64'(r_s5_sum)),
        .o_root (len)
    );

    // Side data waits out stages 4-5 and the square root.
    t_side_a side_a_in, side_a;
    logic    side_a_vld;

    assign side_a_in.mxn = r_s3_mxn;
    assign side_a_in.myn = r_s3_myn;
    assign side_a_in.fr  = r_s3_fr;

    ec2d_delay #(
        .W     ($bits(t_side_a)),
        .DEPTH (34)
    ) u_delay_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_vld   (r_s3_vld),
        .i_data  (side_a_in),
        .o_vld   (side_a_vld),
        .o_data  (side_a)
    );

    // ---------------- Division operands ----------------
    logic [59:0] r_s38_nx_num, r_s38_ny_num;
    logic [31:0] r_s38_len;
    logic [62:0] r_s38_w_num;
    logic [32:0] r_s38_w_den;
    t_side_b     r_s38_side;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_s38_nx_num     <= (60'(side_a.mxn) << ec2d_pkg::NORM_BITS) + 60'(len >> 1);
            r_s38_ny_num     <= (60'(side_a.myn) << ec2d_pkg::NORM_BITS) + 60'(len >> 1);
            r_s38_len        <= len;
            r_s38_w_num      <= (63'(side_a.fr.mb) << ec2d_pkg::WEIGHT_BITS)
                                + 63'(side_a.fr.msum >> 1);
            r_s38_w_den      <= side_a.fr.msum;
            r_s38_side.x_neg <= side_a.fr.x_neg;
            r_s38_side.y_neg <= side_a.fr.y_neg;
            r_s38_side.degen <= side_a.fr.degen;
            r_s38_side.vel   <= side_a.fr.vel;
        end
    end

    logic [30:0] qx, qy, qw;

    ec2d_div #(.NUM_W(60), .DEN_W(32), .Q_W(31)) u_div_nx (
        .i_clk (i_clk),
        .i_en  (pipe_en),
        .i_num (r_s38_nx_num),
        .i_den (r_s38_len),
        .o_quo (qx)
    );

    ec2d_div #(.NUM_W(60), .DEN_W(32), .Q_W(31)) u_div_ny (
        .i_clk (i_clk),
        .i_en  (pipe_en),
        .i_num (r_s38_ny_num),
        .i_den (r_s38_len),
        .o_quo (qy)
    );

    ec2d_div #(.NUM_W(63), .DEN_W(33), .Q_W(31)) u_div_w (
        .i_clk (i_clk),
        .i_en  (pipe_en),
        .i_num (r_s38_w_num),
        .i_den (r_s38_w_den),
        .o_quo (qw)
    );

    t_side_b side_b;
    logic    side_b_vld;

    ec2d_delay #(
        .W     ($bits(t_side_b)),
        .DEPTH (31)
    ) u_delay_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_vld   (r_s38_vld),
        .i_data  (r_s38_side),
        .o_vld   (side_b_vld),
        .o_data  (side_b)
    );

    // ---------------- Signed normal ----------------
    t_back r_n_bk;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_n_bk.degen <= side_b.degen;
            r_n_bk.vel   <= side_b.vel;
            r_n_bk.nx    <= side_b.x_neg ? -$signed({1'b0, qx[28:0]}) : $signed({1'b0, qx[28:0]});
            r_n_bk.ny    <= side_b.y_neg ? -$signed({1'b0, qy[28:0]}) : $signed({1'b0, qy[28:0]});
            r_n_bk.wb    <= qw;
        end
    end

    // ---------------- P1: projection products ----------------
    logic signed [61:0] r_p1_an1, r_p1_an2, r_p1_at1, r_p1_at2;
    logic signed [61:0] r_p1_bn1, r_p1_bn2, r_p1_bt1, r_p1_bt2;
    t_back              r_p1_bk;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_p1_an1 <= 62'($signed(r_n_bk.vel.avx)) * 62'($signed(r_n_bk.nx));
            r_p1_an2 <= 62'($signed(r_n_bk.vel.avy)) * 62'($signed(r_n_bk.ny));
            r_p1_at1 <= 62'($signed(r_n_bk.vel.avy)) * 62'($signed(r_n_bk.nx));
            r_p1_at2 <= 62'($signed(r_n_bk.vel.avx)) * 62'($signed(r_n_bk.ny));
            r_p1_bn1 <= 62'($signed(r_n_bk.vel.bvx)) * 62'($signed(r_n_bk.nx));
            r_p1_bn2 <= 62'($signed(r_n_bk.vel.bvy)) * 62'($signed(r_n_bk.ny));
            r_p1_bt1 <= 62'($signed(r_n_bk.vel.bvy)) * 62'($signed(r_n_bk.nx));
            r_p1_bt2 <= 62'($signed(r_n_bk.vel.bvx)) * 62'($signed(r_n_bk.ny));
            r_p1_bk  <= r_n_bk;
        end
    end

    // ---------------- P2: projection sums ----------------
    logic signed [62:0] r_p2_an, r_p2_at, r_p2_bn, r_p2_bt;
    t_back              r_p2_bk;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_p2_an <= 63'(r_p1_an1) + 63'(r_p1_an2);
            r_p2_at <= 63'(r_p1_at1) - 63'(r_p1_at2);
            r_p2_bn <= 63'(r_p1_bn1) + 63'(r_p1_bn2);
            r_p2_bt <= 63'(r_p1_bt1) - 63'(r_p1_bt2);
            r_p2_bk <= r_p1_bk;
        end
    end

    // ---------------- P3: normal and tangent speeds ----------------
    logic signed [32:0] r_p3_an, r_p3_at, r_p3_bn, r_p3_bt;
    t_back              r_p3_bk;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_p3_an <= 33'(ec2d_pkg::rnd_norm(68'(r_p2_an)));
            r_p3_at <= 33'(ec2d_pkg::rnd_norm(68'(r_p2_at)));
            r_p3_bn <= 33'(ec2d_pkg::rnd_norm(68'(r_p2_bn)));
            r_p3_bt <= 33'(ec2d_pkg::rnd_norm(68'(r_p2_bt)));
            r_p3_bk <= r_p2_bk;
        end
    end

    // ---------------- P4: speed difference and complementary weight ----------------
    logic signed [33:0] delta;
    logic signed [32:0] r_p4_an, r_p4_at, r_p4_bn, r_p4_bt;
    logic [32:0]        r_p4_dmag;
    logic               r_p4_dneg;
    logic [30:0]        r_p4_wa;
    t_back              r_p4_bk;

    assign delta = 34'(r_p3_bn) - 34'(r_p3_an);

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_p4_an   <= r_p3_an;
            r_p4_at   <= r_p3_at;
            r_p4_bn   <= r_p3_bn;
            r_p4_bt   <= r_p3_bt;
            r_p4_dmag <= 33'(delta[33] ? -delta : delta);
            r_p4_dneg <= delta[33];
            r_p4_wa   <= (31'(1) << ec2d_pkg::WEIGHT_BITS) - r_p3_bk.wb;
            r_p4_bk   <= r_p3_bk;
        end
    end

    // ---------------- P5: weighted differences ----------------
    logic [63:0]        r_p5_pa, r_p5_pb;
    logic signed [32:0] r_p5_an, r_p5_at, r_p5_bn, r_p5_bt;
    logic               r_p5_dneg;
    t_back              r_p5_bk;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_p5_pa   <= 64'(r_p4_bk.wb) * 64'(r_p4_dmag);
            r_p5_pb   <= 64'(r_p4_wa) * 64'(r_p4_dmag);
            r_p5_an   <= r_p4_an;
            r_p5_at   <= r_p4_at;
            r_p5_bn   <= r_p4_bn;
            r_p5_bt   <= r_p4_bt;
            r_p5_dneg <= r_p4_dneg;
            r_p5_bk   <= r_p4_bk;
        end
    end

    // ---------------- P6: new normal speeds ----------------
    logic [34:0]        ma, mb;
    logic signed [35:0] ma_s, mb_s;
    logic signed [35:0] r_p6_an2, r_p6_bn2;
    logic signed [32:0] r_p6_at, r_p6_bt;
    t_back              r_p6_bk;

    // The factor of two folds into a shift one short of the weight's fraction.
    assign ma   = 35'((r_p5_pa + (64'd1 << (ec2d_pkg::WEIGHT_BITS - 2)))
                      >> (ec2d_pkg::WEIGHT_BITS - 1));
    assign mb   = 35'((r_p5_pb + (64'd1 << (ec2d_pkg::WEIGHT_BITS - 2)))
                      >> (ec2d_pkg::WEIGHT_BITS - 1));
    assign ma_s = $signed({1'b0, ma});
    assign mb_s = $signed({1'b0, mb});

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            // The difference seen by body B is the negation of the one seen by A.
            r_p6_an2 <= 36'(r_p5_an) + (r_p5_dneg ? -ma_s : ma_s);
            r_p6_bn2 <= 36'(r_p5_bn) + (r_p5_dneg ? mb_s : -mb_s);
            r_p6_at  <= r_p5_at;
            r_p6_bt  <= r_p5_bt;
            r_p6_bk  <= r_p5_bk;
        end
    end

    // ---------------- P7: rebuild products ----------------
    logic signed [65:0] r_p7_xa1, r_p7_xa2, r_p7_ya1, r_p7_ya2;
    logic signed [65:0] r_p7_xb1, r_p7_xb2, r_p7_yb1, r_p7_yb2;
    t_back              r_p7_bk;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_p7_xa1 <= 66'(r_p6_an2) * 66'($signed(r_p6_bk.nx));
            r_p7_xa2 <= 66'(r_p6_at) * 66'($signed(r_p6_bk.ny));
            r_p7_ya1 <= 66'(r_p6_an2) * 66'($signed(r_p6_bk.ny));
            r_p7_ya2 <= 66'(r_p6_at) * 66'($signed(r_p6_bk.nx));
            r_p7_xb1 <= 66'(r_p6_bn2) * 66'($signed(r_p6_bk.nx));
            r_p7_xb2 <= 66'(r_p6_bt) * 66'($signed(r_p6_bk.ny));
            r_p7_yb1 <= 66'(r_p6_bn2) * 66'($signed(r_p6_bk.ny));
            r_p7_yb2 <= 66'(r_p6_bt) * 66'($signed(r_p6_bk.nx));
            r_p7_bk  <= r_p6_bk;
        end
    end

    // ---------------- P8: rebuild sums ----------------
    logic signed [66:0] r_p8_xa, r_p8_ya, r_p8_xb, r_p8_yb;
    t_back              r_p8_bk;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_p8_xa <= 67'(r_p7_xa1) - 67'(r_p7_xa2);
            r_p8_ya <= 67'(r_p7_ya1) + 67'(r_p7_ya2);
            r_p8_xb <= 67'(r_p7_xb1) - 67'(r_p7_xb2);
            r_p8_yb <= 67'(r_p7_yb1) + 67'(r_p7_yb2);
            r_p8_bk <= r_p7_bk;
        end
    end

    // ---------------- P9: back to the velocity scale ----------------
    logic signed [39:0] r_p9_xa, r_p9_ya, r_p9_xb, r_p9_yb;
    t_back              r_p9_bk;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_p9_xa <= 40'(ec2d_pkg::rnd_norm(68'(r_p8_xa)));
            r_p9_ya <= 40'(ec2d_pkg::rnd_norm(68'(r_p8_ya)));
            r_p9_xb <= 40'(ec2d_pkg::rnd_norm(68'(r_p8_xb)));
            r_p9_yb <= 40'(ec2d_pkg::rnd_norm(68'(r_p8_yb)));
            r_p9_bk <= r_p8_bk;
        end
    end

    // ---------------- Output register: clamp or pass through ----------------
    logic [32:0]        cxa, cya, cxb, cyb;
    ec2d_pkg::t_out_res n_out_res, r_out_res;

    assign cxa = ec2d_pkg::clamp32(r_p9_xa);
    assign cya = ec2d_pkg::clamp32(r_p9_ya);
    assign cxb = ec2d_pkg::clamp32(r_p9_xb);
    assign cyb = ec2d_pkg::clamp32(r_p9_yb);

    always_comb begin
        if (r_p9_bk.degen) begin
            n_out_res.first_new_vel_x  = r_p9_bk.vel.avx;
            n_out_res.first_new_vel_y  = r_p9_bk.vel.avy;
            n_out_res.second_new_vel_x = r_p9_bk.vel.bvx;
            n_out_res.second_new_vel_y = r_p9_bk.vel.bvy;
            n_out_res.degenerate       = 1'b1;
            n_out_res.saturated        = 1'b0;
        end else begin
            n_out_res.first_new_vel_x  = $signed(cxa[31:0]);
            n_out_res.first_new_vel_y  = $signed(cya[31:0]);
            n_out_res.second_new_vel_x = $signed(cxb[31:0]);
            n_out_res.second_new_vel_y = $signed(cyb[31:0]);
            n_out_res.degenerate       = 1'b0;
            n_out_res.saturated        = cxa[32] | cya[32] | cxb[32] | cyb[32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_out_res <= n_out_res;
        end
    end

    assign o_res = r_out_res;

    // ---------------- Valid bits ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s38_vld <= 1'b0;
            r_n_vld   <= 1'b0;
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_p3_vld  <= 1'b0;
            r_p4_vld  <= 1'b0;
            r_p5_vld  <= 1'b0;
            r_p6_vld  <= 1'b0;
            r_p7_vld  <= 1'b0;
            r_p8_vld  <= 1'b0;
            r_p9_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (pipe_en) begin
            r_s1_vld  <= i_valid;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_s38_vld <= side_a_vld;
            r_n_vld   <= side_b_vld;
            r_p1_vld  <= r_n_vld;
            r_p2_vld  <= r_p1_vld;
            r_p3_vld  <= r_p2_vld;
            r_p4_vld  <= r_p3_vld;
            r_p5_vld  <= r_p4_vld;
            r_p6_vld  <= r_p5_vld;
            r_p7_vld  <= r_p6_vld;
            r_p8_vld  <= r_p7_vld;
            r_p9_vld  <= r_p8_vld;
            r_out_vld <= r_p9_vld;
        end
    end

`ifndef SYNTHESIS
    a_degen_not_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_res.degenerate && o_res.saturated))
        else $error("degenerate result also flagged as saturated");

    a_request_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_s1_vld)
        else $error("accepted request did not reach the first stage");

    a_freeze_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> ($stable(r_s1_vld) && $stable(r_p9_vld)))
        else $error("pipeline advanced while the result side was stalled");
`endif

endmodule

`default_nettype wire

### test/ec2d_checker.sv
`timescale 1ns / 1ps

module ec2d_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_stall_in,
    input  ec2d_pkg::t_in_req   i_req,
    input  logic                i_res_valid,
    input  logic                i_res_stall,
    input  ec2d_pkg::t_out_res  i_res,
    output int                  o_errors,
    output int                  o_pending
);

    ec2d_pkg::t_out_res collision_q[$];
    int error_count = 0;
    int pending_count = 0;

    function automatic longint unsigned mag(input longint x);
        return x < 0 ? -x : x;
    endfunction

    function automatic longint round_norm(input longint x);
        longint unsigned m;
        m = (mag(x) + (64'd1 << (ec2d_pkg::NORM_BITS - 1))) >> ec2d_pkg::NORM_BITS;
        return x < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic longint bounce_speed(input longint u, input longint other,
                                            input longint unsigned w);
        longint delta;
        longint unsigned m;
        delta = other - u;
        m = (w * mag(delta) + (64'd1 << (ec2d_pkg::WEIGHT_BITS - 2)))
            >> (ec2d_pkg::WEIGHT_BITS - 1);
        return u + (delta < 0 ? -longint'(m) : longint'(m));
    endfunction

    function automatic logic [31:0] sat32(input longint v, inout logic sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'h7fff_ffff;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic ec2d_pkg::t_out_res predict_collision(input ec2d_pkg::t_in_req r);
        ec2d_pkg::t_out_res o;
        longint dx, dy, avx, avy, bvx, bvy, nx, ny, an, at, bn, bt, an2, bn2;
        longint unsigned ma, mb, msum, mx, my, mm, len, wa, wb;
        logic sat;
        dx = longint'(r.first_pos_x) - longint'(r.second_pos_x);
        dy = longint'(r.first_pos_y) - longint'(r.second_pos_y);
        avx = r.first_vel_x;
        avy = r.first_vel_y;
        bvx = r.second_vel_x;
        bvy = r.second_vel_y;
        ma = r.first_mass;
        mb = r.second_mass;
        msum = ma + mb;
        sat = 1'b0;
        o = '0;
        if ((dx == 0 && dy == 0) || msum == 0) begin
            o.first_new_vel_x = r.first_vel_x;
            o.first_new_vel_y = r.first_vel_y;
            o.second_new_vel_x = r.second_vel_x;
            o.second_new_vel_y = r.second_vel_y;
            o.degenerate = 1'b1;
            return o;
        end
        mx = mag(dx);
        my = mag(dy);
        mm = mx > my ? mx : my;
        if (mm >= (64'd1 << 31)) begin
            mx >>= 1;
            my >>= 1;
        end else begin
            while (mm < (64'd1 << 30)) begin
                mm <<= 1;
                mx <<= 1;
                my <<= 1;
            end
        end
        len = int_sqrt(mx * mx + my * my);
        nx = ((mx << ec2d_pkg::NORM_BITS) + len / 2) / len;
        ny = ((my << ec2d_pkg::NORM_BITS) + len / 2) / len;
        if (dx < 0) nx = -nx;
        if (dy < 0) ny = -ny;
        an = round_norm(avx * nx + avy * ny);
        at = round_norm(avy * nx - avx * ny);
        bn = round_norm(bvx * nx + bvy * ny);
        bt = round_norm(bvy * nx - bvx * ny);
        wb = ((mb << ec2d_pkg::WEIGHT_BITS) + msum / 2) / msum;
        wa = (64'd1 << ec2d_pkg::WEIGHT_BITS) - wb;
        an2 = bounce_speed(an, bn, wb);
        bn2 = bounce_speed(bn, an, wa);
        o.first_new_vel_x = sat32(round_norm(an2 * nx - at * ny), sat);
        o.first_new_vel_y = sat32(round_norm(an2 * ny + at * nx), sat);
        o.second_new_vel_x = sat32(round_norm(bn2 * nx - bt * ny), sat);
        o.second_new_vel_y = sat32(round_norm(bn2 * ny + bt * nx), sat);
        o.saturated = sat;
        return o;
    endfunction

    assign o_pending = pending_count;
    assign o_errors = error_count;

    always @(posedge i_clk) begin
        ec2d_pkg::t_out_res exp_res;
        if (i_rst_n && i_valid && !i_stall_in) begin
            collision_q.push_back(predict_collision(i_req));
        end
        if (i_rst_n && i_res_valid && !i_res_stall) begin
            if (collision_q.size() == 0) begin
                $error("result with no request outstanding");
                error_count++;
            end else begin
                exp_res = collision_q.pop_front();
                if (i_res.first_new_vel_x !== exp_res.first_new_vel_x) begin
                    $error("first_new_vel_x exp %h got %h",
                           exp_res.first_new_vel_x, i_res.first_new_vel_x);
                    error_count++;
                end
                if (i_res.first_new_vel_y !== exp_res.first_new_vel_y) begin
                    $error("first_new_vel_y exp %h got %h",
                           exp_res.first_new_vel_y, i_res.first_new_vel_y);
                    error_count++;
                end
                if (i_res.second_new_vel_x !== exp_res.second_new_vel_x) begin
                    $error("second_new_vel_x exp %h got %h",
                           exp_res.second_new_vel_x, i_res.second_new_vel_x);
                    error_count++;
                end
                if (i_res.second_new_vel_y !== exp_res.second_new_vel_y) begin
                    $error("second_new_vel_y exp %h got %h",
                           exp_res.second_new_vel_y, i_res.second_new_vel_y);
                    error_count++;
                end
                if (i_res.degenerate !== exp_res.degenerate) begin
                    $error("degenerate exp %b got %b", exp_res.degenerate, i_res.degenerate);
                    error_count++;
                end
                if (i_res.saturated !== exp_res.saturated) begin
                    $error("saturated exp %b got %b", exp_res.saturated, i_res.saturated);
                    error_count++;
                end
            end
        end
        pending_count = collision_q.size();
    end
endmodule

### test/tb_elastic_collision_2d.sv
`timescale 1ns / 1ps

module tb_elastic_collision_2d;

    localparam int N_RANDOM = 2000;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LATENCY = 80;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    ec2d_pkg::t_in_req i_req;
    logic o_valid;
    logic i_stall;
    ec2d_pkg::t_out_res o_res;
    int errors;
    int pending;
    int idle_cycles;
    bit stim_done;
    bit hold_off;
    bit drained;

    elastic_collision_2d i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_req(i_req), .o_valid(o_valid), .i_stall(i_stall), .o_res(o_res)
    );

    ec2d_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall_in(o_stall),
        .i_req(i_req), .i_res_valid(o_valid), .i_res_stall(i_stall), .i_res(o_res),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 8) - 4;
            3: return {{16{1'b0}}, 16'($urandom)};
            4: return $signed(20'($urandom));
            default: return $urandom;
        endcase
    endfunction

    function automatic ec2d_pkg::t_in_req rand_request();
        ec2d_pkg::t_in_req r;
        r.first_pos_x = rand_word();
        r.first_pos_y = rand_word();
        r.second_pos_x = $urandom_range(0, 9) == 0 ? r.first_pos_x : rand_word();
        r.second_pos_y = $urandom_range(0, 9) == 0 ? r.first_pos_y : rand_word();
        r.first_vel_x = rand_word();
        r.first_vel_y = rand_word();
        r.second_vel_x = rand_word();
        r.second_vel_y = rand_word();
        r.first_mass = $urandom_range(0, 15) == 0 ? 32'd0 : rand_word();
        r.second_mass = $urandom_range(0, 15) == 0 ? 32'd0 : rand_word();
        return r;
    endfunction

    // Valid stays high into the next request when it follows with no gap.
    task automatic send_request(input ec2d_pkg::t_in_req r, input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req <= r;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    // Requests back to back: valid stays high across consecutive requests.
    task automatic send_burst(input int count);
        i_req <= rand_request();
        i_valid <= 1'b1;
        for (int k = 0; k < count; k++) begin
            do @(posedge i_clk); while (o_stall);
            @(negedge i_clk);
            if (k != count - 1) i_req <= rand_request();
        end
    endtask

    task automatic send_directed();
        ec2d_pkg::t_in_req r;
        int k;
        for (k = 0; k < 22; k++) begin
            r = '0;
            r.first_pos_x = 32'sh0001_0000;
            r.first_vel_x = 32'sh0001_0000;
            r.second_vel_x = -32'sh0001_0000;
            r.first_mass = 32'h0001_0000;
            r.second_mass = 32'h0001_0000;
            case (k)
                1: r.first_pos_x = 32'sd0;
                2: r.first_mass = 32'd0;
                3: begin
                    r.first_mass = 32'd0;
                    r.second_mass = 32'd0;
                end
                4: begin
                    r.first_pos_x = 32'h7fff_ffff;
                    r.second_pos_x = 32'h8000_0000;
                end
                5: begin
                    r.first_pos_y = 32'h8000_0000;
                    r.second_pos_y = 32'h7fff_ffff;
                    r.first_pos_x = 32'h8000_0000;
                end
                6: begin
                    r.first_vel_x = 32'h7fff_ffff;
                    r.second_vel_x = 32'h8000_0000;
                end
                7: begin
                    r.first_vel_x = 32'h8000_0000;
                    r.first_vel_y = 32'h8000_0000;
                    r.second_vel_x = 32'h7fff_ffff;
                    r.second_vel_y = 32'h7fff_ffff;
                    r.first_pos_y = 32'h0001_0000;
                end
                8: begin
                    r.first_mass = 32'hffff_ffff;
                    r.second_mass = 32'hffff_ffff;
                end
                9: r.second_mass = 32'd0;
                10: r.first_mass = 32'hffff_ffff;
                11: r.first_pos_x = 32'sd1;
                12: begin
                    r.first_pos_x = 32'sd1;
                    r.first_pos_y = 32'sd1;
                end
                13: begin
                    r.first_pos_x = 32'sh0003_0000;
                    r.first_pos_y = 32'sh0004_0000;
                end
                14: begin
                    r.first_pos_x = -32'sh0005_0000;
                    r.first_pos_y = 32'sh000c_0000;
                    r.first_vel_y = 32'sh0002_0000;
                end
                15: begin
                    r.first_pos_x = 32'sd0;
                    r.first_vel_x = 32'h8000_0000;
                end
                default: r = rand_request();
            endcase
            send_request(r, $urandom_range(0, 3));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req = '0;
        stim_done = 1'b0;
        drained = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_directed();
        for (int n = 0; n < N_RANDOM; ) begin
            if (n >= 600 && !drained) begin
                // Let the result side drain completely before going on.
                drained = 1'b1;
                i_valid <= 1'b0;
                wait (pending == 0);
                @(negedge i_clk);
            end
            if ($urandom_range(0, 3) == 0) begin
                send_burst(20);
                n += 20;
            end else begin
                send_request(rand_request(), $urandom_range(0, 15));
                n++;
            end
        end
        i_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Result side stall, plus one long hold-off while requests keep coming.
    initial begin
        int wait_cycles;
        int res_seen;
        i_stall = 1'b1;
        hold_off = 1'b0;
        res_seen = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!hold_off && res_seen >= 300) begin
                hold_off = 1'b1;
                i_stall <= 1'b1;
                repeat (300) @(negedge i_clk);
            end
            wait_cycles = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
            if (wait_cycles > 0) begin
                i_stall <= 1'b1;
                repeat (wait_cycles) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            res_seen++;
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (stim_done && pending == 0) begin
                repeat (LATENCY + 20) @(posedge i_clk);
                if (errors == 0 && pending == 0) $display("DONE: 0 errors");
                else $display("DONE: errors detected");
                $finish;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end
endmodule
